// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Request, pixel and decoded command types shared by the rasterizer modules.
// ----------------------------------------------------------------------------
package lr_pkg;

	// Command codes carried in the request.
	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Enable flag set on every framebuffer write.
	localparam logic WR_ENABLE_BIT = 1'b1;

	// Input request.
	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  x_start;
		logic [7:0]  y_start;
		logic [7:0]  x_end;
		logic [7:0]  y_end;
		logic [14:0] color;
	} cmd_t;

	// Output pixel write.
	typedef struct packed {
		logic        pixel_valid;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [15:0] fb_address;
		logic [15:0] pixel_data;
		logic        last;
	} pix_t;

	// Classified command with the line setup already worked out.
	typedef struct packed {
		opcode_t            opcode;
		logic [7:0]         x0;
		logic [7:0]         y0;
		logic [7:0]         x1;
		logic [7:0]         y1;
		logic [7:0]         dx;
		logic [7:0]         dy;
		logic               x_neg;
		logic               y_neg;
		logic signed [9:0]  err;
		logic [14:0]        color;
	} line_cmd_t;

endpackage

// ===== rtl/core/lr_front.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts requests and works out the deltas, step signs and initial error.
// ----------------------------------------------------------------------------
module lr_front import lr_pkg::*; (
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  logic      q_full,
	output logic      q_push,
	output line_cmd_t q_data
);

	logic [7:0] dx;
	logic [7:0] dy;
	logic [9:0] half_dy;

	// Take a request whenever the queue has room.
	assign cmd_ready = !q_full;
	assign q_push    = cmd_valid && !q_full;

	// Absolute deltas and the rounded-up half of dy, used when y is the major axis.
	always_comb begin
		dx      = (cmd.x_start > cmd.x_end) ? (cmd.x_start - cmd.x_end)
		                                    : (cmd.x_end - cmd.x_start);
		dy      = (cmd.y_start > cmd.y_end) ? (cmd.y_start - cmd.y_end)
		                                    : (cmd.y_end - cmd.y_start);
		half_dy = ({2'b00, dy} + 10'd1) >> 1;
	end

	// Build the decoded command. An axis with equal ends counts as a negative step.
	always_comb begin
		q_data.opcode = cmd.opcode;
		q_data.x0     = cmd.x_start;
		q_data.y0     = cmd.y_start;
		q_data.x1     = cmd.x_end;
		q_data.y1     = cmd.y_end;
		q_data.dx     = dx;
		q_data.dy     = dy;
		q_data.x_neg  = !(cmd.x_start < cmd.x_end);
		q_data.y_neg  = !(cmd.y_start < cmd.y_end);
		q_data.color  = cmd.color;
		if (dx > dy) begin
			q_data.err = $signed({3'b000, dx[7:1]});
		end else begin
			q_data.err = -$signed(half_dy);
		end
	end

endmodule

// ===== rtl/core/lr_queue.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer command queue
// Short first-in first-out buffer that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lr_queue import lr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  line_cmd_t push_data,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output line_cmd_t head
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	line_cmd_t          mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;

	assign full       = (count_q == CntW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage for queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_q_count_range, clk, arst_n, count_q > CntW'(QUEUE_DEPTH), "queue count overflow")
	`ASSERT_NEVER(a_q_pop_empty, clk, arst_n, pop && (count_q == '0), "pop from empty queue")

endmodule

// ===== rtl/core/lr_back.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer back end
// Holds the line state, steps it once per advance and registers the pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lr_back import lr_pkg::*; #(
	parameter int ROW_WIDTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  line_cmd_t head,
	output logic      pop,
	output pix_t      pix,
	output logic      pix_valid,
	input  logic      pix_ready
);

	localparam logic [15:0] RowW = 16'(ROW_WIDTH);

	// Line state.
	logic [7:0]        cur_x_q;
	logic [7:0]        cur_y_q;
	logic [7:0]        tgt_x_q;
	logic [7:0]        tgt_y_q;
	logic [7:0]        dx_q;
	logic [7:0]        dy_q;
	logic              x_neg_q;
	logic              y_neg_q;
	logic signed [9:0] err_q;
	logic [14:0]       color_q;
	logic              busy_q;

	// Output register.
	pix_t              pix_q;
	logic              pix_valid_q;

	// Next values.
	logic [7:0]        nx_x;
	logic [7:0]        nx_y;
	logic [7:0]        nx_tx;
	logic [7:0]        nx_ty;
	logic signed [9:0] nx_err;
	logic [14:0]       nx_color;
	logic              step_x;
	logic              step_y;
	logic              done;
	logic              emit;
	logic              nx_busy;
	pix_t              pix_d;

	// A command runs when the output register is free or being drained.
	assign pop       = head_valid && (!pix_valid_q || pix_ready);
	assign pix       = pix_q;
	assign pix_valid = pix_valid_q;

	// Bresenham step or new line setup.
	always_comb begin
		step_x   = err_q > -$signed({2'b00, dx_q});
		step_y   = err_q < $signed({2'b00, dy_q});
		nx_x     = cur_x_q;
		nx_y     = cur_y_q;
		nx_tx    = tgt_x_q;
		nx_ty    = tgt_y_q;
		nx_err   = err_q;
		nx_color = color_q;
		emit     = 1'b0;
		if (head.opcode == OP_START) begin
			nx_x     = head.x0;
			nx_y     = head.y0;
			nx_tx    = head.x1;
			nx_ty    = head.y1;
			nx_err   = head.err;
			nx_color = head.color;
			emit     = 1'b1;
		end else if (busy_q) begin
			nx_err = err_q - (step_x ? $signed({2'b00, dy_q}) : 10'sd0)
			               + (step_y ? $signed({2'b00, dx_q}) : 10'sd0);
			if (step_x) begin
				nx_x = x_neg_q ? cur_x_q - 8'd1 : cur_x_q + 8'd1;
			end
			if (step_y) begin
				nx_y = y_neg_q ? cur_y_q - 8'd1 : cur_y_q + 8'd1;
			end
			emit = 1'b1;
		end
		done    = (nx_x == nx_tx) && (nx_y == nx_ty);
		nx_busy = emit ? !done : busy_q;
	end

	// Pixel write; an advance with no active line gives an all-zero result.
	always_comb begin
		pix_d = '0;
		if (emit) begin
			pix_d.pixel_valid = 1'b1;
			pix_d.pixel_x     = nx_x;
			pix_d.pixel_y     = nx_y;
			pix_d.fb_address  = 16'({8'd0, nx_y} * RowW) + {8'd0, nx_x};
			pix_d.pixel_data  = {WR_ENABLE_BIT, nx_color};
			pix_d.last        = done;
		end
	end

	// Line state registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_x_q <= nx_x;
			cur_y_q <= nx_y;
			tgt_x_q <= nx_tx;
			tgt_y_q <= nx_ty;
			err_q   <= nx_err;
			color_q <= nx_color;
			if (head.opcode == OP_START) begin
				dx_q    <= head.dx;
				dy_q    <= head.dy;
				x_neg_q <= head.x_neg;
				y_neg_q <= head.y_neg;
			end
		end
	end

	// Line activity flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= nx_busy;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			pix_q <= pix_d;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (pop) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	`ASSERT_PROP(a_last_ends_line, clk, arst_n, (pop && pix_d.last) |=> !busy_q, "line still active after last pixel")
	`ASSERT_PROP(a_idle_advance_blank, clk, arst_n, (pop && (head.opcode == OP_ADVANCE) && !busy_q) |=> (!pix_q.pixel_valid && (pix_q.pixel_data == '0)), "idle advance produced a pixel")
	`ASSERT_PROP(a_start_sets_pixel, clk, arst_n, (pop && (head.opcode == OP_START)) |=> (pix_q.pixel_valid && pix_q.pixel_data[15]), "start did not emit an enabled pixel")

endmodule

// ===== rtl/core/line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer core
// All-octant Bresenham line rasterizer producing framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Every request gives exactly one response: a start request sets up a line and
// returns its first pixel, an advance request returns the next pixel, and an
// advance with no line active returns a response with pixel_valid low. The core
// sustains one request per cycle while the output is not stalled; a start is no
// slower than an advance because the front end computes the line setup while the
// request is written into a two-entry queue, and the back end then runs one
// error-term update per cycle. An accepted request passes through its queue entry
// and then the output register. The address is pixel_y * ROW_WIDTH + pixel_x, modulo 2^16.
module line_rasterizer_core import lr_pkg::*; #(
	parameter int ROW_WIDTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_ready,
	output pix_t pix,
	output logic pix_valid,
	input  logic pix_ready
);

	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      q_head_valid;
	line_cmd_t q_in;
	line_cmd_t q_head;

	// Request classification.
	lr_front u_front (
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	// Decoupling queue.
	lr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// Line stepping and pixel output.
	lr_back #(
		.ROW_WIDTH (ROW_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.pix        (pix),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready)
	);

endmodule

// ===== sim/tb_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer core testbench
// Sends start and advance requests to the Bresenham rasterizer and checks each
// pixel response. A short table of fixed requests comes first. It covers idle
// advances, single-point lines at the corners of the raster, vertical and
// horizontal lines, and a line abandoned by a new start. Random lines follow,
// most of them walked to their end and some cut short or overrun. A line
// tracker inside the bench predicts every response. Both handshakes stall in
// random bursts.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_core;
	import lr_pkg::*;

	localparam int ROW_W = 256;
	localparam int RANDOM_ITEMS = 1750;
	localparam int QUIET_TAIL = 150;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	pix_t pix;
	logic pix_valid;
	logic pix_ready;

	// One planned request, with a typed-in response where one is given.
	typedef struct {
		cmd_t c;
		bit   typed;
		pix_t want;
	} cmd_entry_t;

	// Fixed table row.
	typedef struct {
		opcode_t     op;
		logic [7:0]  xs;
		logic [7:0]  ys;
		logic [7:0]  xe;
		logic [7:0]  ye;
		logic [14:0] col;
		bit          typed;
		pix_t        want;
	} fixed_row_t;

	// Line tracker state, mirrors the block's registers.
	typedef struct {
		logic [7:0]        cx;
		logic [7:0]        cy;
		logic [7:0]        tx;
		logic [7:0]        ty;
		logic [7:0]        dx;
		logic [7:0]        dy;
		logic              x_neg;
		logic              y_neg;
		logic signed [9:0] err;
		logic [14:0]       col;
		logic              active;
	} line_track_t;

	fixed_row_t fixed_rows [26] = '{
		'{OP_ADVANCE, 8'd255, 8'd255, 8'd255, 8'd255, 15'h7FFF, 1'b1, '0},
		'{OP_START, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b1,
			'{1'b1, 8'd0, 8'd0, 16'h0000, 16'h8000, 1'b1}},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b1, '0},
		'{OP_START, 8'd255, 8'd255, 8'd255, 8'd255, 15'h7FFF, 1'b1,
			'{1'b1, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1}},
		'{OP_START, 8'd255, 8'd0, 8'd255, 8'd0, 15'h001F, 1'b1,
			'{1'b1, 8'd255, 8'd0, 16'h00FF, 16'h801F, 1'b1}},
		'{OP_START, 8'd0, 8'd255, 8'd255, 8'd0, 15'h7C00, 1'b1,
			'{1'b1, 8'd0, 8'd255, 16'hFF00, 16'hFC00, 1'b0}},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_START, 8'd10, 8'd10, 8'd10, 8'd14, 15'h03E0, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_START, 8'd200, 8'd5, 8'd197, 8'd9, 15'h1234, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b1, '0},
		'{OP_START, 8'd3, 8'd7, 8'd9, 8'd7, 15'h2AAA, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b0, '0},
		'{OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 1'b1, '0}
	};

	cmd_entry_t  cmd_plan [$];
	cmd_entry_t  req_now;
	pix_t        pixels_due [$];
	line_track_t track;
	int          mismatches = 0;
	int          responses = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	bit          send_window = 1'b1;
	bit          take_window = 1'b1;

	line_rasterizer_core #(
		.ROW_WIDTH(ROW_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.pix(pix),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Pixel write for the tracker's current position.
	function automatic pix_t plot_pixel(bit is_last);
		pix_t p;
		logic [31:0] addr;
		addr = 32'(track.cy) * 32'(ROW_W) + 32'(track.cx);
		p.pixel_valid = 1'b1;
		p.pixel_x = track.cx;
		p.pixel_y = track.cy;
		p.fb_address = addr[15:0];
		p.pixel_data = {WR_ENABLE_BIT, track.col};
		p.last = is_last;
		return p;
	endfunction

	// Advance the line tracker by one request and return the pixel it gives.
	function automatic pix_t trace_line(cmd_t c);
		int e;
		int ddx;
		int ddy;
		bit done;
		if (c.opcode == OP_START) begin
			track.cx = c.x_start;
			track.cy = c.y_start;
			track.tx = c.x_end;
			track.ty = c.y_end;
			track.col = c.color;
			track.dx = (c.x_start > c.x_end) ? c.x_start - c.x_end : c.x_end - c.x_start;
			track.dy = (c.y_start > c.y_end) ? c.y_start - c.y_end : c.y_end - c.y_start;
			track.x_neg = !(c.x_start < c.x_end);
			track.y_neg = !(c.y_start < c.y_end);
			if (track.dx > track.dy) begin
				track.err = 10'(int'(track.dx) >>> 1);
			end else begin
				track.err = 10'(-((int'(track.dy) + 1) >>> 1));
			end
			done = (track.cx == track.tx) && (track.cy == track.ty);
			track.active = !done;
			return plot_pixel(done);
		end
		if (!track.active) begin
			return '0;
		end
		e = int'(track.err);
		ddx = int'(track.dx);
		ddy = int'(track.dy);
		if (e > -ddx) begin
			track.err = 10'(int'(track.err) - ddy);
			track.cx = track.x_neg ? track.cx - 8'd1 : track.cx + 8'd1;
		end
		if (e < ddy) begin
			track.err = 10'(int'(track.err) + ddx);
			track.cy = track.y_neg ? track.cy - 8'd1 : track.cy + 8'd1;
		end
		done = (track.cx == track.tx) && (track.cy == track.ty);
		if (done) begin
			track.active = 1'b0;
		end
		return plot_pixel(done);
	endfunction

	// A coordinate close to the given one, kept on the raster.
	function automatic logic [7:0] nearby(logic [7:0] v);
		int t;
		t = int'(v) + int'($urandom_range(0, 16)) - 8;
		if (t < 0) begin
			t = 0;
		end else if (t > 255) begin
			t = 255;
		end
		return 8'(t);
	endfunction

	// Queue advance requests with random content in the unused fields.
	task automatic plan_advances(int n);
		cmd_entry_t ent;
		repeat (n) begin
			ent.c = '{OP_ADVANCE, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 15'($urandom)};
			ent.typed = 1'b0;
			ent.want = '0;
			cmd_plan.push_back(ent);
		end
	endtask

	// Queue one random line: mostly short lines walked to the end, some long ones,
	// some cut short by the next start, some overrun; at times only idle advances.
	task automatic plan_line();
		cmd_entry_t ent;
		logic [7:0] x0;
		logic [7:0] y0;
		logic [7:0] x1;
		logic [7:0] y1;
		int span;
		int len;
		int kind;
		int tail;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			plan_advances($urandom_range(1, 4));
			return;
		end
		x0 = 8'($urandom);
		y0 = 8'($urandom);
		if (kind == 7) begin
			x1 = 8'($urandom);
			y1 = 8'($urandom);
		end else if (kind == 8) begin
			// Mostly axis-aligned lines.
			span = $urandom_range(0, 20);
			x1 = ($urandom_range(0, 2) == 0) ? x0 : nearby(x0);
			y1 = ($urandom_range(0, 1) == 0) ? y0 : 8'(x0 > 200 ? y0 - span : y0 + span);
			if (x1 == x0 && y1 == y0) begin
				x1 = 8'(x0 + span);
			end
		end else begin
			x1 = nearby(x0);
			y1 = nearby(y0);
		end
		ent.c = '{OP_START, x0, y0, x1, y1, 15'($urandom)};
		ent.typed = 1'b0;
		ent.want = '0;
		cmd_plan.push_back(ent);
		len = int'((x0 > x1) ? x0 - x1 : x1 - x0);
		span = int'((y0 > y1) ? y0 - y1 : y1 - y0);
		if (span > len) begin
			len = span;
		end
		tail = $urandom_range(0, 9);
		if (tail == 7 && len > 0) begin
			plan_advances($urandom_range(0, len - 1));
		end else if (tail >= 8) begin
			plan_advances(len + $urandom_range(1, 3));
		end else begin
			plan_advances(len);
		end
	endtask

	// Report one mismatch and count it.
	task automatic report_mismatch(string what, int got, int want);
		$display("response %0d: %s is %0h, expected %0h", responses, what, got, want);
		mismatches++;
	endtask

	// Cycle count, idle windows and the run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 97 == 0) begin
			send_window <= ($urandom_range(0, 2) != 0);
			take_window <= ($urandom_range(0, 2) != 0);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("line_rasterizer_core: mismatch");
			$finish;
		end
	end

	// Check each accepted pixel, then predict the pixel of each accepted request.
	always @(posedge clk) begin : scoreboard
		pix_t want;
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("unexpected response", int'(pix.fb_address), 0);
				end else begin
					want = pixels_due.pop_front();
					if (pix.pixel_valid !== want.pixel_valid)
						report_mismatch("pixel_valid", pix.pixel_valid, want.pixel_valid);
					if (pix.pixel_x !== want.pixel_x)
						report_mismatch("pixel_x", pix.pixel_x, want.pixel_x);
					if (pix.pixel_y !== want.pixel_y)
						report_mismatch("pixel_y", pix.pixel_y, want.pixel_y);
					if (pix.fb_address !== want.fb_address)
						report_mismatch("fb_address", pix.fb_address, want.fb_address);
					if (pix.pixel_data !== want.pixel_data)
						report_mismatch("pixel_data", pix.pixel_data, want.pixel_data);
					if (pix.last !== want.last)
						report_mismatch("last", pix.last, want.last);
				end
				responses++;
			end
			if (cmd_valid && cmd_ready) begin
				want = trace_line(req_now.c);
				pixels_due.push_back(req_now.typed ? req_now.want : want);
			end
		end
	end

	// Response side: ready drops in bursts inside stall windows.
	initial begin
		pix_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && take_window && $urandom_range(0, 4) == 0) begin
				pix_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			pix_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Reset, request plan, request driver and the end of the run.
	initial begin
		cmd_entry_t ent;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		req_now.c = '0;
		req_now.typed = 1'b0;
		req_now.want = '0;
		track = '{default: '0};
		foreach (fixed_rows[i]) begin
			ent.c = '{fixed_rows[i].op, fixed_rows[i].xs, fixed_rows[i].ys,
				fixed_rows[i].xe, fixed_rows[i].ye, fixed_rows[i].col};
			ent.typed = fixed_rows[i].typed;
			ent.want = fixed_rows[i].want;
			cmd_plan.push_back(ent);
		end
		while (cmd_plan.size() < $size(fixed_rows) + RANDOM_ITEMS) begin
			plan_line();
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (cmd_plan.size() != 0) begin
			quiet = (cmd_plan.size() < QUIET_TAIL);
			if (!quiet && send_window && $urandom_range(0, 3) == 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			ent = cmd_plan.pop_front();
			cmd <= ent.c;
			req_now <= ent;
			cmd_valid <= 1'b1;
			do @(posedge clk); while (!cmd_ready);
		end
		cmd_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("line_rasterizer_core: match");
		end else begin
			$display("line_rasterizer_core: mismatch");
		end
		$finish;
	end

endmodule
